// File: hw/rtl/dvcb_pkg.sv
package dvcb_pkg;

    typedef enum logic [2:0] {
        FUNC_UPDATE  = 3'd0,
        FUNC_PUSH    = 3'd1,
        FUNC_POP     = 3'd2,
        FUNC_SET_VT  = 3'd3,
        FUNC_ADVANCE = 3'd4,
        FUNC_RESTAMP = 3'd5,
        FUNC_FACTOR  = 3'd6,
        FUNC_INIT    = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STALE    = 3'd1,
        ST_BEHIND   = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_ZERO_FAC = 3'd5
    } status_t;

    localparam logic [1:0] REG_BARRIER_LIFE  = 2'd0;
    localparam logic [1:0] REG_START_VIRTUAL = 2'd1;
    localparam logic [1:0] REG_START_REAL    = 2'd2;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: hw/rtl/dvcb_ram.sv
module dvcb_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/dvcb_div.sv
module dvcb_div
    import dvcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num_hi,
    input  logic [63:0] num_lo,
    input  logic [63:0] den,
    output div_status_t stat,
    output logic [63:0] quot
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] shifted;
    logic        carry;

    always_comb
    begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        carry     = rem_reg[63];
        shifted   = {rem_reg[62:0], lo_reg[63]};
        if (start)
        begin
            den_next = den;
            if ((den == 64'd0) || (num_hi >= den))
            begin
                // quotient overflows: saturate, finish at once
                q_next    = ALL_ONES;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = num_hi;
                lo_next   = num_lo;
                q_next    = 64'd0;
                cnt_next  = 7'd64;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            lo_next = {lo_reg[62:0], 1'b0};
            if (carry || (shifted >= den_reg))
            begin
                rem_next = shifted - den_reg;
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

// File: hw/rtl/dilated_virtual_clock_with_barriers_unit.sv
// Dilated virtual clock with a barrier stack.
// Input channel (in_valid/in_ready) carries one command transaction: func,
// real_time and value. Output channel (out_valid/out_ready) returns exactly one
// result transaction per command: virtual_time, popped_limit and status.
// Commands are processed one at a time. Update, advance and set factor (when
// not stale) form the 128-bit elapsed-time product in the partial-product and
// product registers, start the restoring divider (one quotient bit per cycle),
// then commit and hand the result over; a quotient that saturates skips the
// iterations. Push, set virtual, restamp, init and stale commands go straight
// to the hand-over, and pop first takes the entry below the top from the RAM.
// The divider sets the rate.
// The barrier stack lives in a synchronous RAM (limit and deadline per entry);
// the top barrier is held in registers, so a pop reads the RAM the cycle before.
// A finished result sits in an output register; the next command is accepted
// while it waits, and a command that completes while the receiver still stalls
// holds until the register frees. Reset (rst_n, async, active low) clears the
// clock to zero, dilation to UNIT, the top barrier to all ones and the stack to
// empty; stack RAM needs no clearing since entries are read only after a push.
// Configuration registers (64-bit APB): barrier_life at 0x00, start_virtual
// at 0x08, start_real at 0x10.
module dilated_virtual_clock_with_barriers_unit
    import dvcb_pkg::*;
#(
    parameter int              STACK_DEPTH = 16,
    parameter longint unsigned UNIT        = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [63:0] real_time,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] virtual_time,
    output logic [63:0] popped_limit,
    output logic [2:0]  status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);
    localparam logic [32:0]   UnitC  = 33'(UNIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_SUM,
        S_DIV,
        S_POP,
        S_DONE
    } state_t;

    state_t state_reg;

    // config registers
    logic [63:0] life_reg, start_v_reg, start_r_reg;
    // clock state
    logic [63:0] cv_reg, last_reg, dil_reg, tlim_reg, tdl_reg;
    logic [CW-1:0] cnt_reg;
    // latched command
    logic [2:0]  func_reg;
    logic [63:0] now_reg, val_reg;
    // product pipeline
    logic [64:0]  pp_lo_reg, pp_hi_reg;
    logic [127:0] prod_reg;
    logic         div_start_reg;
    // pending result
    logic [63:0] res_p_reg;
    logic [2:0]  res_s_reg;
    // output register
    logic [63:0] o_v_reg, o_p_reg;
    logic [2:0]  o_s_reg;
    logic        o_valid_reg;

    logic         wr_en;
    logic [63:0]  elapsed;
    logic         in_acc;
    logic         ram_we;
    logic [127:0] ram_rdata;
    div_status_t  dstat;
    logic [63:0]  quot;
    logic [63:0]  sum_v, clamp_v, adv_v;
    logic         stale;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ALL_ONES : s[63:0];
    endfunction

    function automatic logic [63:0] clamp(input logic [63:0] cv, input logic [63:0] lr,
                                          input logic [63:0] lim, input logic [63:0] dl,
                                          input logic [63:0] v);
        logic [63:0] r;
        if (cv >= lim)
        begin
            r = (lr > dl) ? v : cv;
        end
        else
        begin
            r = (lim < v) ? lim : v;
        end
        return r;
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid & in_ready;
    assign elapsed  = now_reg - last_reg;
    assign stale    = (last_reg >= now_reg);

    // read-back of the configuration registers
    always_comb
    begin
        unique case (paddr[4:3])
            REG_BARRIER_LIFE:  prdata = life_reg;
            REG_START_VIRTUAL: prdata = start_v_reg;
            REG_START_REAL:    prdata = start_r_reg;
            default:           prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            life_reg    <= 64'd0;
            start_v_reg <= 64'd0;
            start_r_reg <= 64'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:3])
                REG_BARRIER_LIFE:  life_reg    <= pwdata;
                REG_START_VIRTUAL: start_v_reg <= pwdata;
                REG_START_REAL:    start_r_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    // push saves the current top barrier at the slot given by the count
    assign ram_we = (state_reg == S_EXEC) && (func_reg == FUNC_PUSH) && (cnt_reg < DepthC);

    dvcb_ram #(
        .WIDTH(128),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(cnt_reg[AW-1:0]),
        .wdata({tlim_reg, tdl_reg}),
        .raddr(AW'(cnt_reg - CW'(1))),
        .rdata(ram_rdata)
    );

    dvcb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num_hi(prod_reg[127:64]),
        .num_lo(prod_reg[63:0]),
        .den   (dil_reg),
        .stat  (dstat),
        .quot  (quot)
    );

    // commit arithmetic: saturate, apply the barrier, add advance amount
    assign sum_v   = sat_add(cv_reg, quot);
    assign clamp_v = clamp(cv_reg, last_reg, tlim_reg, tdl_reg, sum_v);
    assign adv_v   = sat_add(clamp_v, (func_reg == FUNC_ADVANCE) ? val_reg : 64'd0);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg <= func;
            now_reg  <= real_time;
            val_reg  <= value;
        end
        pp_lo_reg <= {33'd0, elapsed[31:0]} * {32'd0, UnitC};
        pp_hi_reg <= {33'd0, elapsed[63:32]} * {32'd0, UnitC};
        prod_reg  <= {63'd0, pp_lo_reg} + {31'd0, pp_hi_reg, 32'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cv_reg        <= 64'd0;
            last_reg      <= 64'd0;
            dil_reg       <= 64'(UNIT);
            tlim_reg      <= ALL_ONES;
            tdl_reg       <= ALL_ONES;
            cnt_reg       <= '0;
            div_start_reg <= 1'b0;
            res_p_reg     <= 64'd0;
            res_s_reg     <= ST_OK;
            o_valid_reg   <= 1'b0;
            o_v_reg       <= 64'd0;
            o_p_reg       <= 64'd0;
            o_s_reg       <= ST_OK;
        end
        else
        begin
            // start the divider in the cycle after the product settles
            div_start_reg <= (state_reg == S_SUM);
            if (o_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                o_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_p_reg <= 64'd0;
                    case (func_reg) inside
                        FUNC_UPDATE, FUNC_ADVANCE:
                        begin
                            if (stale)
                            begin
                                res_s_reg <= ST_STALE;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                res_s_reg <= ST_OK;
                                state_reg <= S_MUL;
                            end
                        end
                        FUNC_FACTOR:
                        begin
                            if (stale)
                            begin
                                // skip the update silently, just change factor unless it is zero
                                state_reg <= S_DONE;
                                if (val_reg == 64'd0)
                                begin
                                    res_s_reg <= ST_ZERO_FAC;
                                end
                                else
                                begin
                                    res_s_reg <= ST_OK;
                                    dil_reg   <= val_reg;
                                end
                            end
                            else
                            begin
                                res_s_reg <= ST_OK;
                                state_reg <= S_MUL;
                            end
                        end
                        FUNC_PUSH:
                        begin
                            state_reg <= S_DONE;
                            if (cnt_reg >= DepthC)
                            begin
                                res_s_reg <= ST_FULL;
                            end
                            else
                            begin
                                res_s_reg <= ST_OK;
                                cnt_reg   <= cnt_reg + CW'(1);
                                if (val_reg < tlim_reg)
                                begin
                                    tlim_reg <= val_reg;
                                end
                                tdl_reg <= sat_add(now_reg, life_reg);
                            end
                        end
                        FUNC_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_s_reg <= ST_EMPTY;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                res_s_reg <= ST_OK;
                                state_reg <= S_POP;
                            end
                        end
                        FUNC_SET_VT:
                        begin
                            state_reg <= S_DONE;
                            if (cv_reg >= val_reg)
                            begin
                                res_s_reg <= ST_BEHIND;
                            end
                            else
                            begin
                                res_s_reg <= ST_OK;
                                cv_reg   <= clamp(cv_reg, last_reg, tlim_reg, tdl_reg,
                                                  val_reg);
                                last_reg <= now_reg;
                            end
                        end
                        FUNC_RESTAMP:
                        begin
                            res_s_reg <= ST_OK;
                            state_reg <= S_DONE;
                            last_reg  <= now_reg;
                        end
                        default:
                        begin
                            res_s_reg <= ST_OK;
                            state_reg <= S_DONE;
                            cv_reg   <= start_v_reg;
                            last_reg <= start_r_reg;
                            dil_reg  <= 64'(UNIT);
                            tlim_reg <= ALL_ONES;
                            tdl_reg  <= ALL_ONES;
                            cnt_reg  <= '0;
                        end
                    endcase
                end
                S_MUL:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (dstat.done)
                    begin
                        cv_reg    <= adv_v;
                        last_reg  <= now_reg;
                        state_reg <= S_DONE;
                        if (func_reg == FUNC_FACTOR)
                        begin
                            if (val_reg == 64'd0)
                            begin
                                res_s_reg <= ST_ZERO_FAC;
                            end
                            else
                            begin
                                dil_reg <= val_reg;
                            end
                        end
                    end
                end
                S_POP:
                begin
                    // RAM output holds the entry below the top
                    res_p_reg <= tlim_reg;
                    tlim_reg  <= ram_rdata[127:64];
                    tdl_reg   <= ram_rdata[63:0];
                    cnt_reg   <= cnt_reg - CW'(1);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!o_valid_reg || out_ready)
                    begin
                        o_valid_reg <= 1'b1;
                        o_v_reg     <= cv_reg;
                        o_p_reg     <= res_p_reg;
                        o_s_reg     <= res_s_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = o_valid_reg;
    assign virtual_time = o_v_reg;
    assign popped_limit = o_p_reg;
    assign status       = o_s_reg;

    cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DepthC)
        else $error("stack count beyond depth");

    dil_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        dil_reg != 64'd0)
        else $error("dilation became zero");

    push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("stack write without count advance");

    div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        dstat.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside divide state");

endmodule

// File: tb/sv/tb_dilated_virtual_clock_with_barriers_unit.sv
`timescale 1ns / 100ps

module tb_dilated_virtual_clock_with_barriers_unit;
    import dvcb_pkg::*;

    localparam int              DEPTH      = 16;
    localparam longint unsigned UNIT_STEP  = 65536;
    localparam int              CYCLE_CAP  = 3000000;
    localparam int              LONG_HOLD  = 600;
    localparam int              MAX_REPORT = 10;

    typedef struct {
        func_t       fn;
        logic [63:0] rt;
        logic [63:0] val;
    } clock_cmd_t;

    typedef struct {
        logic [63:0] vt;
        logic [63:0] pl;
        status_t     st;
    } clock_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [63:0] real_time;
    logic [63:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] virtual_time;
    logic [63:0] popped_limit;
    logic [2:0]  status;

    // Commands waiting to be offered, and results the block still owes.
    clock_cmd_t    cmd_queue[$];
    clock_result_t owed_results[$];

    // Mirror of the clock state and the configuration registers.
    logic [63:0] m_life;
    logic [63:0] m_start_vt;
    logic [63:0] m_start_rt;
    logic [63:0] m_vt;
    logic [63:0] m_last_rt;
    logic [63:0] m_dilation;
    logic [63:0] m_top_limit;
    logic [63:0] m_top_deadline;
    logic [63:0] m_saved_limit[DEPTH];
    logic [63:0] m_saved_deadline[DEPTH];
    int          m_count;

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_request;
    int          error_count;
    int          cycle_count;
    logic [63:0] rt_cursor;

    dilated_virtual_clock_with_barriers_unit #(
        .STACK_DEPTH(DEPTH),
        .UNIT       (UNIT_STEP)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .real_time   (real_time),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .virtual_time(virtual_time),
        .popped_limit(popped_limit),
        .status      (status)
    );

    // Toggle the clock every half period of 10 ns.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ALL_ONES : s[63:0];
    endfunction

    // Scaled step: floor(dt * UNIT / factor), saturating when it overflows 64 bits.
    function automatic logic [63:0] scaled_step(logic [63:0] dt, logic [63:0] fac);
        logic [127:0] prod;
        logic [127:0] quo;
        prod = {64'd0, dt} * {64'd0, UNIT_STEP};
        if (fac == 64'd0 || prod[127:64] >= fac)
            return ALL_ONES;
        quo = prod / {64'd0, fac};
        return quo[63:0];
    endfunction

    // Hold virtual time at the top barrier until its deadline has passed.
    function automatic logic [63:0] apply_barrier(logic [63:0] v);
        if (m_vt >= m_top_limit)
            return (m_last_rt > m_top_deadline) ? v : m_vt;
        return (m_top_limit < v) ? m_top_limit : v;
    endfunction

    function automatic bit advance_clock(logic [63:0] now, logic [63:0] extra);
        logic [63:0] v;
        if (m_last_rt >= now)
            return 1'b0;
        v      = apply_barrier(add_sat(m_vt, scaled_step(now - m_last_rt, m_dilation)));
        m_vt      = add_sat(v, extra);
        m_last_rt = now;
        return 1'b1;
    endfunction

    // Apply one command to the mirror and return the result it must produce.
    function automatic clock_result_t predict_clock(clock_cmd_t c);
        clock_result_t r;
        r.pl = 64'd0;
        r.st = ST_OK;
        case (c.fn)
            FUNC_UPDATE:
                if (!advance_clock(c.rt, 64'd0))
                    r.st = ST_STALE;
            FUNC_PUSH:
                if (m_count >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    m_saved_limit[m_count]    = m_top_limit;
                    m_saved_deadline[m_count] = m_top_deadline;
                    m_count++;
                    if (c.val < m_top_limit)
                        m_top_limit = c.val;
                    m_top_deadline = add_sat(c.rt, m_life);
                end
            FUNC_POP:
                if (m_count == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    r.pl = m_top_limit;
                    m_count--;
                    m_top_limit    = m_saved_limit[m_count];
                    m_top_deadline = m_saved_deadline[m_count];
                end
            FUNC_SET_VT:
                if (m_vt >= c.val)
                    r.st = ST_BEHIND;
                else
                begin
                    m_vt      = apply_barrier(c.val);
                    m_last_rt = c.rt;
                end
            FUNC_ADVANCE:
                if (!advance_clock(c.rt, c.val))
                    r.st = ST_STALE;
            FUNC_RESTAMP:
                m_last_rt = c.rt;
            FUNC_FACTOR:
            begin
                void'(advance_clock(c.rt, 64'd0));
                if (c.val == 64'd0)
                    r.st = ST_ZERO_FAC;
                else
                    m_dilation = c.val;
            end
            default:
            begin
                m_vt           = m_start_vt;
                m_last_rt      = m_start_rt;
                m_dilation     = UNIT_STEP;
                m_top_limit    = ALL_ONES;
                m_top_deadline = ALL_ONES;
                m_count        = 0;
            end
        endcase
        r.vt = m_vt;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Pick an operand: often small, sometimes near real time, full-width or extreme.
    function automatic logic [63:0] rand_operand();
        int k;
        k = $urandom_range(99);
        if (k < 45)
            return 64'($urandom_range(1 << 20));
        if (k < 60)
            return rt_cursor + 64'($urandom_range(200000));
        if (k < 85)
            return rand64();
        if (k < 93)
            return ALL_ONES;
        return 64'd0;
    endfunction

    // Mostly move real time forward; sometimes go stale, repeat, or jump.
    function automatic logic [63:0] rand_real_time();
        int k;
        k = $urandom_range(99);
        if (k < 84)
            rt_cursor = rt_cursor + 64'($urandom_range(1, 5000));
        else if (k < 90)
            return rt_cursor - 64'($urandom_range(0, 3000));
        else if (k < 95)
            rt_cursor = rand64();
        else if (k < 97)
            rt_cursor = ALL_ONES - 64'($urandom_range(20));
        return rt_cursor;
    endfunction

    task automatic queue_cmd(func_t fn, logic [63:0] rt, logic [63:0] val);
        clock_cmd_t c;
        c.fn  = fn;
        c.rt  = rt;
        c.val = val;
        cmd_queue.push_back(c);
    endtask

    // Queue n random commands; a factor mostly stays within 1 to 4*UNIT so the clock keeps moving visibly.
    task automatic queue_random(int n);
        int    k;
        int    i;
        func_t fn;
        for (i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 3)
            begin
                // Fill the stack past its depth and then pop a random number of entries, possibly all.
                repeat (DEPTH + 2) queue_cmd(FUNC_PUSH, rand_real_time(), rand_operand());
                repeat ($urandom_range(DEPTH + 2)) queue_cmd(FUNC_POP, rand_real_time(), rand64());
                continue;
            end
            if (k < 30)      fn = FUNC_UPDATE;
            else if (k < 45) fn = FUNC_PUSH;
            else if (k < 60) fn = FUNC_POP;
            else if (k < 70) fn = FUNC_SET_VT;
            else if (k < 80) fn = FUNC_ADVANCE;
            else if (k < 86) fn = FUNC_RESTAMP;
            else if (k < 95) fn = FUNC_FACTOR;
            else             fn = FUNC_INIT;
            if (fn == FUNC_FACTOR && $urandom_range(3) != 0)
                queue_cmd(fn, rand_real_time(), 64'($urandom_range(1, 1 << 18)));
            else
                queue_cmd(fn, rand_real_time(), rand_operand());
        end
    endtask

    // Two-phase APB write: setup, then access; the register takes it at the access edge.
    task automatic apb_write(logic [1:0] idx, logic [63:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BARRIER_LIFE:  m_life     = data;
            REG_START_VIRTUAL: m_start_vt = data;
            default:           m_start_rt = data;
        endcase
    endtask

    task automatic configure(logic [63:0] life, logic [63:0] svt, logic [63:0] srt);
        apb_write(REG_BARRIER_LIFE, life);
        apb_write(REG_START_VIRTUAL, svt);
        apb_write(REG_START_REAL, srt);
    endtask

    // Wait until every queued command is accepted and every result is back.
    task automatic drain();
        while (cmd_queue.size() != 0 || in_valid || owed_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Driver: retire the accepted transaction, then offer the next one unless idling.
    always @(posedge clk or negedge rst_n)
    begin
        bit          taken;
        bit          offer;
        clock_result_t r;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            func      <= FUNC_UPDATE;
            real_time <= 64'd0;
            value     <= 64'd0;
        end
        else
        begin
            taken = in_valid && in_ready;
            if (taken)
            begin
                r = predict_clock(cmd_queue[0]);
                owed_results.push_back(r);
                void'(cmd_queue.pop_front());
            end
            if (in_valid && !taken)
                offer = 1'b1;
            else
                offer = (cmd_queue.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            in_valid <= offer;
            if (offer)
            begin
                func      <= cmd_queue[0].fn;
                real_time <= cmd_queue[0].rt;
                value     <= cmd_queue[0].val;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        int  hold_left;
        bit  hold_used;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            hold_used = 1'b0;
        end
        else
        begin
            if (hold_request && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each result transaction with the oldest owed result.
    always @(posedge clk)
    begin
        clock_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORT)
                    $display("unexpected result: vt=%h pl=%h st=%0d",
                             virtual_time, popped_limit, status);
            end
            else
            begin
                e = owed_results.pop_front();
                if (virtual_time !== e.vt || popped_limit !== e.pl || status !== e.st)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORT)
                        $display("mismatch: exp vt=%h pl=%h st=%0d  got vt=%h pl=%h st=%0d",
                                 e.vt, e.pl, e.st, virtual_time, popped_limit, status);
                end
            end
        end
    end

    // Guard against a hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("** dilated_virtual_clock_with_barriers_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 30;
        recv_idle_pct  = 49;
        hold_request   = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        rt_cursor      = 64'd1000;
        m_life         = 64'd0;
        m_start_vt     = 64'd0;
        m_start_rt     = 64'd0;
        m_vt           = 64'd0;
        m_last_rt      = 64'd0;
        m_dilation     = UNIT_STEP;
        m_top_limit    = ALL_ONES;
        m_top_deadline = ALL_ONES;
        m_count        = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: short barrier life, then each command and its corner cases.
        configure(64'd2000, 64'd500, 64'd900);
        queue_cmd(FUNC_UPDATE, 64'd0, 64'd0);               // stale at reset
        queue_cmd(FUNC_UPDATE, 64'd100, 64'd0);
        queue_cmd(FUNC_POP, 64'd110, 64'd0);                // empty stack
        queue_cmd(FUNC_PUSH, 64'd120, 64'd1 << 30);
        queue_cmd(FUNC_UPDATE, 64'd50000, ALL_ONES);        // stays below the limit
        queue_cmd(FUNC_UPDATE, 64'd60000, 64'd0);           // deadline passed
        queue_cmd(FUNC_PUSH, 64'd60001, ALL_ONES);          // limit kept from the top
        queue_cmd(FUNC_POP, 64'd60002, 64'd0);
        queue_cmd(FUNC_POP, 64'd60003, 64'd0);
        queue_cmd(FUNC_SET_VT, 64'd60004, 64'd0);           // virtual behind
        queue_cmd(FUNC_SET_VT, 64'd60005, ALL_ONES - 64'd5);
        queue_cmd(FUNC_ADVANCE, 64'd60010, ALL_ONES);       // saturating sum
        queue_cmd(FUNC_ADVANCE, 64'd60010, 64'd1);          // stale advance
        queue_cmd(FUNC_INIT, ALL_ONES, ALL_ONES);
        queue_cmd(FUNC_FACTOR, 64'd2000, 64'd0);            // zero factor rejected
        queue_cmd(FUNC_FACTOR, 64'd3000, 64'd1);
        queue_cmd(FUNC_UPDATE, ALL_ONES, 64'd0);            // step saturates
        queue_cmd(FUNC_RESTAMP, 64'd10, 64'd0);
        queue_cmd(FUNC_INIT, 64'd0, 64'd0);
        queue_cmd(FUNC_FACTOR, 64'd1000, ALL_ONES);
        queue_cmd(FUNC_UPDATE, ALL_ONES, 64'd0);            // tiny step
        queue_cmd(FUNC_ADVANCE, ALL_ONES - 64'd1, 64'd7);   // stale at high time
        queue_cmd(FUNC_RESTAMP, 64'd0, ALL_ONES);
        queue_random(225);
        drain();

        // Swap the idling pattern and run with extreme registers.
        send_idle_pct = 49;
        recv_idle_pct = 30;
        configure(ALL_ONES, ALL_ONES, ALL_ONES);
        queue_random(225);
        drain();

        // No idling; hold the receiver off long enough to back up the input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(64'd0, 64'd0, 64'd0);
        rt_cursor = 64'd5000;
        queue_random(225);
        @(negedge clk);
        hold_request = 1'b1;
        drain();

        if (error_count == 0)
            $display("** dilated_virtual_clock_with_barriers_unit: PASSED **");
        else
            $display("** dilated_virtual_clock_with_barriers_unit: FAILED **");
        $finish;
    end

endmodule
